// ===== rtl/pat_pkg.sv =====
// Shared types, codes and constants of the paged address translator.
// No dependencies; every other file of the block but pat_ram refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package pat_pkg;

  // Fixed field widths of the request and result channels
  localparam int unsigned LADDR_W     = 16;
  localparam int unsigned MASK_W      = 16;
  localparam int unsigned MASK_IW     = 4;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned PHYS_ADDR_W = 10;
  localparam int unsigned VICTIM_W    = 4;
  localparam int unsigned COUNT_W     = 32;

  // Parameter defaults for the top level
  localparam int unsigned PAGE_COUNT_DEF    = 16;
  localparam int unsigned FRAME_COUNT_DEF   = 8;
  localparam int unsigned OFFSET_WIDTH_DEF  = 7;
  localparam int unsigned ADDRESS_WIDTH_DEF = 16;

  typedef enum logic [STATUS_W-1:0] {
    STAT_HIT         = 3'd0,
    STAT_FAULT_FREE  = 3'd1,
    STAT_FAULT_EVICT = 3'd2,
    STAT_RANGE       = 3'd3,
    STAT_PROTECT     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FSCAN,
    ST_VSCAN,
    ST_VFRAME,
    ST_LOAD
  } state_e;

  // Counter update request from the sequencer
  typedef struct packed {
    logic access;
    logic hit;
    logic fault;
  } cnt_evt_t;

endpackage

`default_nettype wire

// ===== rtl/pat_if.sv =====
// Valid/ready channel interfaces for translation requests and results.
// Depends on pat_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pat_req_if;
  logic                        valid;
  logic                        ready;
  logic [pat_pkg::LADDR_W-1:0] logical_address;
  logic                        is_write;

  modport source (output valid, logical_address, is_write, input ready);
  modport sink   (input valid, logical_address, is_write, output ready);
endinterface

interface pat_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [pat_pkg::STATUS_W-1:0]    status;
  logic [pat_pkg::PHYS_ADDR_W-1:0] physical_address;
  logic [pat_pkg::VICTIM_W-1:0]    victim_page;
  logic                            victim_was_dirty;
  logic [pat_pkg::COUNT_W-1:0]     access_total;
  logic [pat_pkg::COUNT_W-1:0]     fault_total;
  logic [pat_pkg::COUNT_W-1:0]     hit_total;

  modport source (output valid, status, physical_address, victim_page, victim_was_dirty,
                  access_total, fault_total, hit_total, input ready);
  modport sink   (input valid, status, physical_address, victim_page, victim_was_dirty,
                  access_total, fault_total, hit_total, output ready);
endinterface

`default_nettype wire

// ===== rtl/pat_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/pat_counters.sv =====
// Saturating access, fault and hit counters of the translator.
// Depends on pat_pkg for the counter width and the update struct.
`timescale 1ns / 1ps
`default_nettype none

module pat_counters (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire pat_pkg::cnt_evt_t           evt_i,
  output      logic [pat_pkg::COUNT_W-1:0] access_o,
  output      logic [pat_pkg::COUNT_W-1:0] fault_o,
  output      logic [pat_pkg::COUNT_W-1:0] hit_o
);

  logic [pat_pkg::COUNT_W-1:0] access_q, access_d;
  logic [pat_pkg::COUNT_W-1:0] fault_q, fault_d;
  logic [pat_pkg::COUNT_W-1:0] hit_q, hit_d;

  // Hold at all ones once reached
  always_comb begin
    access_d = access_q;
    fault_d  = fault_q;
    hit_d    = hit_q;
    if (evt_i.access && (access_q != '1)) access_d = access_q + 1'b1;
    if (evt_i.fault  && (fault_q  != '1)) fault_d  = fault_q + 1'b1;
    if (evt_i.hit    && (hit_q    != '1)) hit_d    = hit_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      access_q <= '0;
      fault_q  <= '0;
      hit_q    <= '0;
    end else begin
      access_q <= access_d;
      fault_q  <= fault_d;
      hit_q    <= hit_d;
    end
  end

  assign access_o = access_q;
  assign fault_o  = fault_q;
  assign hit_o    = hit_q;

endmodule

`default_nettype wire

// ===== rtl/paged_address_translator_unit.sv =====
// Sequence: a hit or an error finishes in the check state; a fault first scans the frames
// upward for a free one and loads into it, and with no free frame runs the second-chance
// page sweep, reads the victim's frame and then loads; the scan unit walks one index per cycle.
// Throughput: one request at a time; the next is taken once the result register frees.
// Reset: asynchronous active low; page flags, frame map, counters and mask clear.
// The frame table RAM has no reset, and its read data is only used for present pages.
`timescale 1ns / 1ps
`default_nettype none

module paged_address_translator_unit #(
  parameter int unsigned PAGE_COUNT    = pat_pkg::PAGE_COUNT_DEF,
  parameter int unsigned FRAME_COUNT   = pat_pkg::FRAME_COUNT_DEF,
  parameter int unsigned OFFSET_WIDTH  = pat_pkg::OFFSET_WIDTH_DEF,
  parameter int unsigned ADDRESS_WIDTH = pat_pkg::ADDRESS_WIDTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  pat_req_if.sink                         req_i,
  pat_rsp_if.source                       rsp_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [pat_pkg::MASK_W-1:0] cfg_wdata_i
);

  // Index widths: pages, frames, and the shared scan counter that walks both
  localparam int unsigned PIW = $clog2(PAGE_COUNT);
  localparam int unsigned FIW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int unsigned SCW = (PIW > FIW) ? PIW : FIW;
  localparam int unsigned PAW = FIW + OFFSET_WIDTH;
  localparam logic [31:0] ADDR_MASK =
    (ADDRESS_WIDTH >= 32) ? 32'hFFFF_FFFF : ((32'h1 << ADDRESS_WIDTH) - 32'h1);
  localparam logic [SCW-1:0] LAST_FRAME = SCW'(FRAME_COUNT - 1);
  localparam logic [SCW-1:0] LAST_PAGE  = SCW'(PAGE_COUNT - 1);

  // ---------------------------------------------------------------------------
  // Request decode, straight from the channel so the frame RAM read can start
  // in the cycle the request is taken.
  // ---------------------------------------------------------------------------
  logic [31:0]             in_addr;
  logic [31:0]             in_page;
  logic                    in_range_err;
  logic                    in_prot_err;
  logic                    req_fire;
  logic [pat_pkg::MASK_W-1:0] ro_mask_q;

  assign in_addr      = {{(32 - pat_pkg::LADDR_W){1'b0}}, req_i.logical_address} & ADDR_MASK;
  assign in_page      = in_addr >> OFFSET_WIDTH;
  assign in_range_err = (in_page >= 32'(PAGE_COUNT));
  // Only the first sixteen pages can be protected
  assign in_prot_err  = req_i.is_write && (in_page < 32'(pat_pkg::MASK_W)) &&
                        ro_mask_q[in_page[pat_pkg::MASK_IW-1:0]];

  // Latched request
  logic [PIW-1:0]          pg_q;
  logic [OFFSET_WIDTH-1:0] off_q;
  logic                    wr_q;
  logic                    range_err_q;
  logic                    prot_err_q;
  logic [FIW-1:0]          frame_q, frame_d;

  // ---------------------------------------------------------------------------
  // Page and frame state
  // ---------------------------------------------------------------------------
  logic [PAGE_COUNT-1:0]  present_q, present_d;
  logic [PAGE_COUNT-1:0]  dirty_q, dirty_d;
  logic [PAGE_COUNT-1:0]  ref_q, ref_d;
  logic [FRAME_COUNT-1:0] fiu_q, fiu_d;

  // Frame table: one entry per page, written on load, read at one address
  logic           ram_we;
  logic [PIW-1:0] ram_raddr;
  logic [FIW-1:0] ram_rdata;

  pat_ram #(
    .WIDTH (FIW),
    .DEPTH (PAGE_COUNT)
  ) u_frame_tbl (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pg_q),
    .wdata_i (frame_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Sequencer and scan unit
  // ---------------------------------------------------------------------------
  pat_pkg::state_e state_q, state_d;
  logic [SCW-1:0]  idx_q, idx_d;
  logic [PIW-1:0]  first_q, first_d;
  logic            have_first_q, have_first_d;
  logic [PIW-1:0]  victim_q, victim_d;
  logic            evict_q, evict_d;

  logic [PIW-1:0]  scan_pg;
  logic [FIW-1:0]  scan_fr;
  logic            cur_present;
  logic            cur_ref;
  logic [PIW-1:0]  fallback_pg;

  // Result staging
  logic                            fin;
  pat_pkg::status_e                res_status;
  logic [PAW-1:0]                  res_phys;
  logic [PIW-1:0]                  res_victim;
  logic                            res_vdirty;
  pat_pkg::cnt_evt_t               cnt_evt;

  logic                            out_valid_q;
  logic [pat_pkg::STATUS_W-1:0]    out_status_q;
  logic [pat_pkg::PHYS_ADDR_W-1:0] out_phys_q;
  logic [pat_pkg::VICTIM_W-1:0]    out_victim_q;
  logic                            out_vdirty_q;
  logic [pat_pkg::PHYS_ADDR_W+PAW-1:0]    phys_ext;
  logic [pat_pkg::VICTIM_W+PIW-1:0]       victim_ext;

  assign scan_pg     = idx_q[PIW-1:0];
  assign scan_fr     = idx_q[FIW-1:0];
  assign cur_present = present_q[scan_pg];
  assign cur_ref     = ref_q[scan_pg];
  // Lowest present page seen so far, including the one under the scan now
  assign fallback_pg = have_first_q ? first_q : scan_pg;

  assign req_fire = req_i.valid && req_i.ready;
  // Take a request only while idle and with the result register free or draining
  assign req_i.ready = (state_q == pat_pkg::ST_IDLE) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    first_d      = first_q;
    have_first_d = have_first_q;
    victim_d     = victim_q;
    frame_d      = frame_q;
    evict_d      = evict_q;
    present_d    = present_q;
    dirty_d      = dirty_q;
    ref_d        = ref_q;
    fiu_d        = fiu_q;
    ram_we       = 1'b0;
    ram_raddr    = in_page[PIW-1:0];
    fin          = 1'b0;
    res_status   = pat_pkg::STAT_HIT;
    res_phys     = '0;
    res_victim   = '0;
    res_vdirty   = 1'b0;
    cnt_evt      = '0;

    case (state_q)
      pat_pkg::ST_IDLE: begin
        if (req_fire) state_d = pat_pkg::ST_CHECK;
      end

      pat_pkg::ST_CHECK: begin
        if (range_err_q || prot_err_q) begin
          // Error: count the access only, touch no page state
          fin            = 1'b1;
          res_status     = range_err_q ? pat_pkg::STAT_RANGE : pat_pkg::STAT_PROTECT;
          cnt_evt.access = 1'b1;
          state_d        = pat_pkg::ST_IDLE;
        end else if (present_q[pg_q]) begin
          // Hit: frame read started when the request was taken
          fin            = 1'b1;
          res_status     = pat_pkg::STAT_HIT;
          res_phys       = {ram_rdata, off_q};
          cnt_evt.access = 1'b1;
          cnt_evt.hit    = 1'b1;
          ref_d[pg_q]    = 1'b1;
          if (wr_q) dirty_d[pg_q] = 1'b1;
          state_d        = pat_pkg::ST_IDLE;
        end else begin
          idx_d   = '0;
          state_d = pat_pkg::ST_FSCAN;
        end
      end

      // Walk the frames upward for the first free one
      pat_pkg::ST_FSCAN: begin
        if (!fiu_q[scan_fr]) begin
          frame_d = scan_fr;
          evict_d = 1'b0;
          state_d = pat_pkg::ST_LOAD;
        end else if (idx_q == LAST_FRAME) begin
          idx_d        = '0;
          have_first_d = 1'b0;
          state_d      = pat_pkg::ST_VSCAN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      // Second-chance sweep: drop referenced bits until an unreferenced page turns up
      pat_pkg::ST_VSCAN: begin
        if (cur_present && !cur_ref) begin
          victim_d  = scan_pg;
          ram_raddr = scan_pg;
          state_d   = pat_pkg::ST_VFRAME;
        end else begin
          if (cur_present) begin
            ref_d[scan_pg] = 1'b0;
            if (!have_first_q) begin
              first_d      = scan_pg;
              have_first_d = 1'b1;
            end
          end
          if (idx_q == LAST_PAGE) begin
            if (have_first_q || cur_present) begin
              // Every present page was referenced: take the lowest one
              victim_d  = fallback_pg;
              ram_raddr = fallback_pg;
              state_d   = pat_pkg::ST_VFRAME;
            end else begin
              // No present page at all: load into frame zero, evict nothing
              frame_d = '0;
              evict_d = 1'b0;
              state_d = pat_pkg::ST_LOAD;
            end
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end

      pat_pkg::ST_VFRAME: begin
        frame_d = (32'(ram_rdata) >= 32'(FRAME_COUNT)) ? '0 : ram_rdata;
        evict_d = 1'b1;
        state_d = pat_pkg::ST_LOAD;
      end

      pat_pkg::ST_LOAD: begin
        fin            = 1'b1;
        res_phys       = {frame_q, off_q};
        cnt_evt.access = 1'b1;
        cnt_evt.fault  = 1'b1;
        if (evict_q) begin
          res_status          = pat_pkg::STAT_FAULT_EVICT;
          res_victim          = victim_q;
          res_vdirty          = dirty_q[victim_q];
          present_d[victim_q] = 1'b0;
          dirty_d[victim_q]   = 1'b0;
          ref_d[victim_q]     = 1'b0;
        end else begin
          res_status = pat_pkg::STAT_FAULT_FREE;
        end
        fiu_d[frame_q] = 1'b1;
        present_d[pg_q] = 1'b1;
        dirty_d[pg_q]   = wr_q;
        ref_d[pg_q]     = 1'b1;
        ram_we          = 1'b1;
        state_d         = pat_pkg::ST_IDLE;
      end

      default: begin
        state_d = pat_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pat_pkg::ST_IDLE;
      idx_q        <= '0;
      have_first_q <= 1'b0;
      evict_q      <= 1'b0;
      present_q    <= '0;
      dirty_q      <= '0;
      ref_q        <= '0;
      fiu_q        <= '0;
      ro_mask_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      have_first_q <= have_first_d;
      evict_q      <= evict_d;
      present_q    <= present_d;
      dirty_q      <= dirty_d;
      ref_q        <= ref_d;
      fiu_q        <= fiu_d;
      if (cfg_we_i) ro_mask_q <= cfg_wdata_i;
      // Raise on a finished request, drop once the result is taken
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers, no reset needed
  assign phys_ext   = {{pat_pkg::PHYS_ADDR_W{1'b0}}, res_phys};
  assign victim_ext = {{pat_pkg::VICTIM_W{1'b0}}, res_victim};

  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    victim_q <= victim_d;
    frame_q  <= frame_d;
    if (req_fire) begin
      pg_q        <= in_page[PIW-1:0];
      off_q       <= in_addr[OFFSET_WIDTH-1:0];
      wr_q        <= req_i.is_write;
      range_err_q <= in_range_err;
      prot_err_q  <= in_prot_err;
    end
    if (fin) begin
      out_status_q <= res_status;
      out_phys_q   <= phys_ext[pat_pkg::PHYS_ADDR_W-1:0];
      out_victim_q <= victim_ext[pat_pkg::VICTIM_W-1:0];
      out_vdirty_q <= res_vdirty;
    end
  end

  // Counters step on the same edge that loads the result register and stay put
  // while the result waits, so the result shows them directly.
  pat_counters u_counters (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .evt_i    (cnt_evt),
    .access_o (rsp_o.access_total),
    .fault_o  (rsp_o.fault_total),
    .hit_o    (rsp_o.hit_total)
  );

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.status           = out_status_q;
  assign rsp_o.physical_address = out_phys_q;
  assign rsp_o.victim_page      = out_victim_q;
  assign rsp_o.victim_was_dirty = out_vdirty_q;

endmodule

`default_nettype wire

// ===== rtl/pat_checker.sv =====
// Port-level checks of the translator, attached to the top level by bind.
// Depends on pat_pkg for widths and status codes.
`timescale 1ns / 1ps
`default_nettype none

module pat_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            req_valid_i,
  input wire logic                            req_ready_i,
  input wire logic                            rsp_valid_i,
  input wire logic                            rsp_ready_i,
  input wire logic [pat_pkg::STATUS_W-1:0]    status_i,
  input wire logic [pat_pkg::PHYS_ADDR_W-1:0] phys_i,
  input wire logic [pat_pkg::VICTIM_W-1:0]    victim_i,
  input wire logic                            vdirty_i,
  input wire logic [pat_pkg::COUNT_W-1:0]     access_i,
  input wire logic [pat_pkg::COUNT_W-1:0]     fault_i,
  input wire logic [pat_pkg::COUNT_W-1:0]     hit_i
);

  // Hold a pending result until taken
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped before it was taken");

  // One request at a time: busy right after a request is taken
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while the previous one is still at work");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && ((status_i == pat_pkg::STAT_RANGE) || (status_i == pat_pkg::STAT_PROTECT))
    |-> (phys_i == '0) && (victim_i == '0) && !vdirty_i)
    else $error("error result carries a nonzero address or victim");

  a_no_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i != pat_pkg::STAT_FAULT_EVICT) |-> (victim_i == '0) && !vdirty_i)
    else $error("victim reported without eviction");

  // Every hit and every fault is also an access
  a_count_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (access_i >= hit_i) && (access_i >= fault_i) &&
                    (access_i != '0))
    else $error("counters out of order");

endmodule

bind paged_address_translator_unit pat_checker u_pat_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .status_i    (rsp_o.status),
  .phys_i      (rsp_o.physical_address),
  .victim_i    (rsp_o.victim_page),
  .vdirty_i    (rsp_o.victim_was_dirty),
  .access_i    (rsp_o.access_total),
  .fault_i     (rsp_o.fault_total),
  .hit_i       (rsp_o.hit_total)
);

`default_nettype wire
